// ===== src/ill_pkg.sv =====
`default_nettype none
package ill_pkg;
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INS_AFTER = 3'd1;
	localparam logic [2:0] OP_INS_BEFORE = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_REMOVE_TAIL = 3'd4;
	localparam logic [2:0] OP_READ = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_DEAD = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch request and read entry at pos / tail
		logic link;      // read next free-stack link
		logic commit;    // write updated links and registers
	} ill_cmd_t;
endpackage
`default_nettype wire

// ===== src/indexed_linked_list_manager.sv =====
// Doubly linked list over a fixed table of SLOTS entries with a free stack
// threaded through the next links. One operation per input transaction
// (append, insert after/before, remove slot, remove tail, read) and exactly
// one output transaction per input, reporting status, the touched slot, its
// value and links, and head, tail and count after the operation. Link value
// SLOTS means none. The result reaches the output register through the
// steps read free-stack link, decide and commit; the next input is taken in
// the cycle after the result has moved into the output register, so a new
// input is not accepted while the last one is still in flight.
// A stalled sink holds the commit step until the output register drains.
`default_nettype none
module indexed_linked_list_manager
	import ill_pkg::*;
#(
	parameter int SLOTS = 16,
	parameter int VALUE_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [39:0] s_tdata,  // op[2:0], pos[6:3], value[38:7], zero fill
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [63:0] m_tdata  // status, slot, value_out, prev_out, next_out,
	                              // head_pos, tail_pos, count
);
	ill_cmd_t cmd;
	logic in_fire, out_load, out_busy;
	logic [1:0] r_status;
	logic [4:0] r_slot, r_prev, r_next, r_head, r_tail, r_count;
	logic [31:0] r_value;
	logic [63:0] out_q;
	logic out_valid_q;

	assign in_fire = s_tvalid && s_tready;
	// output register busy unless empty or being drained this cycle
	assign out_busy = out_valid_q && !m_tready;

	ill_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(out_busy),
		.in_ready(s_tready), .out_load(out_load), .cmd(cmd)
	);

	ill_dpath #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.op(s_tdata[2:0]), .pos(s_tdata[6:3]), .value(s_tdata[38:7]),
		.r_status(r_status), .r_slot(r_slot), .r_value(r_value),
		.r_prev(r_prev), .r_next(r_next), .r_head(r_head),
		.r_tail(r_tail), .r_count(r_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {r_count, r_tail, r_head, r_next, r_prev, r_value,
				r_slot, r_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;
endmodule
`default_nettype wire

// ===== src/ill_ctrl.sv =====
`default_nettype none
module ill_ctrl
	import ill_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_busy,
	output logic in_ready,
	output logic out_load,
	output ill_cmd_t cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LINK = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_WAIT = 2'd3;

	logic [1:0] state_q;

	assign in_ready = (state_q == S_IDLE);
	assign cmd.capture = in_fire;
	assign cmd.link = (state_q == S_LINK);
	assign cmd.commit = (state_q == S_WAIT) && !out_busy;
	assign out_load = cmd.commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_LINK;
				S_LINK: state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_WAIT;
				S_WAIT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_commit_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !in_ready) else $error("commit while idle");
	a_link_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> cmd.link) else $error("link step missed");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.link, cmd.commit})) else $error("commands overlap");
endmodule
`default_nettype wire

// ===== src/ill_dpath.sv =====
`default_nettype none
module ill_dpath
	import ill_pkg::*;
#(
	parameter int SLOTS = 16,
	parameter int VALUE_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ill_cmd_t cmd,
	input wire logic [2:0] op,
	input wire logic [3:0] pos,
	input wire logic [31:0] value,
	output logic [1:0] r_status,
	output logic [4:0] r_slot,
	output logic [31:0] r_value,
	output logic [4:0] r_prev,
	output logic [4:0] r_next,
	output logic [4:0] r_head,
	output logic [4:0] r_tail,
	output logic [4:0] r_count
);
	localparam int IW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] NONE = LW'(SLOTS);

	// link and value stores: next links are loaded with i+1 at reset so the
	// free stack starts as the whole table in index order
	logic [LW-1:0] next_q [SLOTS];
	logic [LW-1:0] prev_q [SLOTS];
	logic [VALUE_BITS-1:0] val_q [SLOTS];
	logic [SLOTS-1:0] occ_q;
	logic [LW-1:0] head_q, tail_q, free_q, cnt_q;

	logic [2:0] op_q;
	logic [LW-1:0] tgt_q, nb_q, x_next_q, x_prev_q, new_q;
	logic [VALUE_BITS-1:0] val_in_q, x_val_q;
	logic tgt_live_q;

	function automatic logic live(input logic [LW-1:0] x, input logic [SLOTS-1:0] o);
		live = (x < LW'(SLOTS)) && o[x[IW-1:0]];
	endfunction

	// capture: pick target, read its entry
	logic [LW-1:0] tgt_c;
	always_comb begin
		tgt_c = (op == OP_REMOVE_TAIL) ? tail_q : LW'(pos);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op;
			tgt_q <= tgt_c;
			val_in_q <= VALUE_BITS'(value);
			tgt_live_q <= live(tgt_c, occ_q);
			new_q <= free_q;
			if (tgt_c < LW'(SLOTS)) begin
				x_next_q <= next_q[tgt_c[IW-1:0]];
				x_prev_q <= prev_q[tgt_c[IW-1:0]];
				x_val_q <= val_q[tgt_c[IW-1:0]];
			end else begin
				x_next_q <= NONE;
				x_prev_q <= NONE;
				x_val_q <= '0;
			end
		end
		if (cmd.link) begin
			nb_q <= (free_q < LW'(SLOTS)) ? next_q[free_q[IW-1:0]] : NONE;
		end
	end

	// decision
	logic ins, full, empty_c, ok;
	always_comb begin
		ins = (op_q == OP_APPEND) || (op_q == OP_INS_AFTER) || (op_q == OP_INS_BEFORE);
		full = (free_q >= LW'(SLOTS));
		empty_c = (cnt_q == '0) || (head_q >= LW'(SLOTS));
		ok = 1'b0;
		r_status = ST_OK;
		if (ins) begin
			if (full) r_status = ST_FULL;
			else if (op_q != OP_APPEND && !tgt_live_q) r_status = ST_DEAD;
			else ok = 1'b1;
		end else if (op_q == OP_REMOVE || op_q == OP_REMOVE_TAIL) begin
			if (empty_c) r_status = ST_EMPTY;
			else if (!tgt_live_q) r_status = ST_DEAD;
			else ok = 1'b1;
		end else if (op_q == OP_READ) begin
			if (!tgt_live_q) r_status = ST_DEAD;
			else ok = 1'b1;
		end
	end

	logic rd, rm;
	assign rd = ok && (op_q == OP_READ);
	assign rm = ok && (op_q == OP_REMOVE || op_q == OP_REMOVE_TAIL);
	assign r_slot = !ok ? NONE : (ins ? new_q : tgt_q);
	assign r_value = 32'((rd || rm) ? x_val_q : '0);
	assign r_prev = 5'(rd ? x_prev_q : NONE);
	assign r_next = 5'(rd ? x_next_q : NONE);

	// post-operation head, tail, count
	logic [LW-1:0] head_n, tail_n, cnt_n;
	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		cnt_n = cnt_q;
		if (ok && ins) begin
			cnt_n = cnt_q + 1'b1;
			if (op_q == OP_APPEND) begin
				if (tail_q >= LW'(SLOTS)) head_n = new_q;
				tail_n = new_q;
			end else if (op_q == OP_INS_AFTER) begin
				if (x_next_q >= LW'(SLOTS)) tail_n = new_q;
			end else begin
				if (x_prev_q >= LW'(SLOTS)) head_n = new_q;
			end
		end else if (rm) begin
			cnt_n = cnt_q - 1'b1;
			if (x_prev_q >= LW'(SLOTS)) head_n = x_next_q;
			if (x_next_q >= LW'(SLOTS)) tail_n = x_prev_q;
		end
	end
	assign r_head = 5'(head_n);
	assign r_tail = 5'(tail_n);
	assign r_count = 5'(cnt_n);

	// commit: links (up to three entries), control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NONE;
			tail_q <= NONE;
			free_q <= '0;
			cnt_q <= '0;
			occ_q <= '0;
			for (int i = 0; i < SLOTS; i++) next_q[i] <= LW'(i + 1);
		end else if (cmd.commit) begin
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q <= cnt_n;
			if (ok && ins) begin
				free_q <= nb_q;
				occ_q[new_q[IW-1:0]] <= 1'b1;
				if (op_q == OP_APPEND) begin
					next_q[new_q[IW-1:0]] <= NONE;
					if (tail_q < LW'(SLOTS)) next_q[tail_q[IW-1:0]] <= new_q;
				end else if (op_q == OP_INS_AFTER) begin
					next_q[new_q[IW-1:0]] <= x_next_q;
					next_q[tgt_q[IW-1:0]] <= new_q;
				end else begin
					next_q[new_q[IW-1:0]] <= tgt_q;
					if (x_prev_q < LW'(SLOTS)) next_q[x_prev_q[IW-1:0]] <= new_q;
				end
			end else if (rm) begin
				if (x_prev_q < LW'(SLOTS)) next_q[x_prev_q[IW-1:0]] <= x_next_q;
				next_q[tgt_q[IW-1:0]] <= free_q;
				free_q <= tgt_q;
				occ_q[tgt_q[IW-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (ok && ins) begin
				val_q[new_q[IW-1:0]] <= val_in_q;
				if (op_q == OP_APPEND) begin
					prev_q[new_q[IW-1:0]] <= tail_q;
				end else if (op_q == OP_INS_AFTER) begin
					prev_q[new_q[IW-1:0]] <= tgt_q;
					if (x_next_q < LW'(SLOTS)) prev_q[x_next_q[IW-1:0]] <= new_q;
				end else begin
					prev_q[new_q[IW-1:0]] <= x_prev_q;
					prev_q[tgt_q[IW-1:0]] <= new_q;
				end
			end else if (rm) begin
				if (x_next_q < LW'(SLOTS)) prev_q[x_next_q[IW-1:0]] <= x_prev_q;
			end
		end
	end

	a_count_occ: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_q) == int'(cnt_q)) else $error("count disagrees with occupancy");
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (head_q == NONE && tail_q == NONE)) else $error("empty list has ends");
	a_free_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q < LW'(SLOTS)) |-> !occ_q[free_q[IW-1:0]]) else $error("free top is live");
endmodule
`default_nettype wire
